[hw/rtl/assert_macros.svh]
// assertion macros used by nearest_palette_color_match
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold on a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/npc_pkg.sv]
// types and constants of the nearest palette color match block
package npc_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned SizeW           = 9;
  localparam int unsigned DistW           = 18;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(256);
  localparam logic [DistW-1:0] DistStart = DistW'(3 * 256 * 256);
  localparam logic [DistW-1:0] RedLimit  = DistW'(128 * 128);
  localparam logic [DistW-1:0] RgLimit   = DistW'(2 * 128 * 128);

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } npc_in_t;

  typedef struct packed {
    logic [7:0] best_index;
    logic       matched;
  } npc_out_t;

endpackage

[hw/rtl/nearest_palette_color_match.sv]
// nearest palette color match: a write request stores one entry in the palette memory; a
// query request walks the palette memory one entry per cycle through its single read port,
// scanning min(palette_size, PALETTE_DEPTH) entries, and stalls further requests until its
// search is over and any previous result has left the output register. its result leaves
// through that register, which lets a following write or query start while the result still
// waits to be taken. unwritten entries must not be searched; the palette has no reset.
`include "assert_macros.svh"

module nearest_palette_color_match
  import npc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  npc_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output npc_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW  = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned SW  = (CW > SizeW) ? CW : SizeW;
  localparam int unsigned IW  = (AW > 8) ? AW : 8;

  // palette memory
  logic [23:0]    mem_q [PALETTE_DEPTH];
  logic [23:0]    rdata_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic           mem_re;
  logic [IW-1:0]  widx;

  // control
  logic             in_acc;
  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    limit_q;
  logic [CW-1:0]    limit_d;
  logic [SW-1:0]    size_ext;
  logic [SizeW-1:0] size_q;
  logic             s1_vld_q, s2_vld_q;
  logic [AW-1:0]    s1_idx_q, s2_idx_q;
  logic             done;
  logic             out_vld_q;

  // query and search state
  logic [7:0]       q_r_q, q_g_q, q_b_q;
  logic [7:0]       df_r, df_g, df_b;
  logic [15:0]      sq_r_q, sq_g_q, sq_b_q;
  logic [DistW-1:0] d_rg, d_all;
  logic             keep;
  logic [DistW-1:0] best_dist_q;
  logic [AW-1:0]    best_idx_q;
  logic             found_q;
  logic [IW-1:0]    best_ext;
  npc_out_t         out_q;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  assign widx      = IW'(in_data_i.entry_index);
  assign mem_waddr = widx[AW-1:0];
  assign mem_we    = in_acc && (in_data_i.opcode == OpWrite) &&
                     (32'(in_data_i.entry_index) < 32'(PALETTE_DEPTH));
  assign mem_re    = busy_q && (cnt_q < limit_q);

  // oversized palette_size saturates to the memory depth
  always_comb begin
    size_ext = SW'(size_q);
    if (size_ext > SW'(PALETTE_DEPTH)) begin
      limit_d = CW'(PALETTE_DEPTH);
    end else begin
      limit_d = size_ext[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    end
    if (mem_re) begin
      rdata_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  // pipeline drained, scan over and output register free
  assign done = busy_q && !mem_re && !s1_vld_q && !s2_vld_q &&
                (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      size_q    <= SizeReset;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      s1_vld_q <= mem_re;
      s2_vld_q <= s1_vld_q;
      if (in_acc && (in_data_i.opcode == OpQuery)) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (mem_re) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (done) begin
        busy_q    <= 1'b0;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign df_r = (q_r_q > rdata_q[23:16]) ? q_r_q - rdata_q[23:16] : rdata_q[23:16] - q_r_q;
  assign df_g = (q_g_q > rdata_q[15:8])  ? q_g_q - rdata_q[15:8]  : rdata_q[15:8] - q_g_q;
  assign df_b = (q_b_q > rdata_q[7:0])   ? q_b_q - rdata_q[7:0]   : rdata_q[7:0] - q_b_q;

  // pruning on red, then red plus green, then strict improvement
  assign d_rg  = DistW'(sq_r_q) + DistW'(sq_g_q);
  assign d_all = d_rg + DistW'(sq_b_q);
  assign keep  = (DistW'(sq_r_q) <= RedLimit) && (d_rg <= RgLimit) && (d_all < best_dist_q);

  assign best_ext = IW'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.opcode == OpQuery)) begin
      q_r_q       <= in_data_i.red;
      q_g_q       <= in_data_i.green;
      q_b_q       <= in_data_i.blue;
      limit_q     <= limit_d;
      best_dist_q <= DistStart;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
    end else if (s2_vld_q && keep) begin
      best_dist_q <= d_all;
      best_idx_q  <= s2_idx_q;
      found_q     <= 1'b1;
    end
    if (mem_re) begin
      s1_idx_q <= cnt_q[AW-1:0];
    end
    if (s1_vld_q) begin
      sq_r_q   <= 16'(df_r) * 16'(df_r);
      sq_g_q   <= 16'(df_g) * 16'(df_g);
      sq_b_q   <= 16'(df_b) * 16'(df_b);
      s2_idx_q <= s1_idx_q;
    end
    if (done) begin
      out_q.best_index <= found_q ? best_ext[7:0] : 8'd0;
      out_q.matched    <= found_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_read_only_busy, clk_i, rst_ni,
              (s1_vld_q || s2_vld_q) |-> busy_q, "read outside query")
  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni,
              busy_q |-> (cnt_q <= limit_q), "scan past limit")
  `ASSERT_CLK(a_found_dist, clk_i, rst_ni,
              (busy_q && found_q) |-> (best_dist_q < DistStart), "best distance not updated")
  `ASSERT_NEVER(a_nomatch_idx, clk_i, rst_ni,
                out_vld_q && !out_q.matched && (out_q.best_index != 8'd0),
                "unmatched result with nonzero index")

endmodule
